// ===== sv/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for barometric compensation
// Field widths, pipeline stage counts, register indexes, calibration struct.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int RAW_W         = 24;
  localparam int TEMP_W        = 24;
  localparam int PRESS_W       = 26;
  localparam int CFG_W         = 48;
  localparam int LIMB_W        = 24;
  localparam int TEMP_STAGES   = 4;
  localparam int PRESS_STAGES  = 11;
  localparam int TEMP_MAX      = 8388607;
  localparam int TEMP_MIN      = -8388608;
  localparam int PRESS_MAX     = 67108863;

  typedef enum logic [1:0] {
    CFG_TEMP_CALIB,
    CFG_PRESS_LOW,
    CFG_PRESS_MID,
    CFG_PRESS_HIGH
  } cfg_reg_t;

  // decoded coefficients; signed ones are read through $signed()
  typedef struct packed {
    logic [15:0] t1;   // unsigned
    logic [16:0] t2;   // zero-extended u16
    logic [7:0]  t3;
    logic [16:0] p1;   // s16 minus 2^14
    logic [16:0] p2;   // s16 minus 2^14
    logic [7:0]  p3;
    logic [7:0]  p4;
    logic [16:0] p5;   // zero-extended u16
    logic [16:0] p6;   // zero-extended u16
    logic [7:0]  p7;
    logic [7:0]  p8;
    logic [15:0] p9;
    logic [7:0]  p10;
    logic [7:0]  p11;
  } calib_t;

endpackage

`default_nettype wire

// ===== sv/bpc_wmul.sv =====
// ----------------------------------------------------------------------------
// bpc_wmul: two-stage signed multiplier, wide operand cut into 24-bit limbs
// Stage A registers limb partial products, stage B registers their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_wmul
  import bpc_pkg::*;
#(
  parameter int AW = 24,
  parameter int BW = 24
) (
  input  wire logic                    clk,
  input  wire logic                    en_a,
  input  wire logic                    en_b,
  input  wire logic signed [AW-1:0]    a,
  input  wire logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0]      p
);

  localparam int NL  = (AW + LIMB_W - 1) / LIMB_W;
  localparam int EXT = NL * LIMB_W;
  localparam int PPW = LIMB_W + 1 + BW;
  localparam int SW  = EXT + BW + 1;
  localparam int PW  = AW + BW;

  logic signed [EXT-1:0] a_ext;
  logic signed [PPW-1:0] pp_next [NL];
  logic signed [PPW-1:0] pp      [NL];
  logic signed [SW-1:0]  acc;

  assign a_ext = EXT'(a);

  always_comb begin
    for (int k = 0; k < NL - 1; k++) begin
      pp_next[k] = PPW'($signed({1'b0, a_ext[k*LIMB_W +: LIMB_W]}) * b);
    end
    // top limb carries the sign
    pp_next[NL-1] = PPW'($signed(a_ext[(NL-1)*LIMB_W +: LIMB_W]) * b);
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      pp <= pp_next;
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NL; k++) begin
      acc = acc + (SW'(pp[k]) <<< (k * LIMB_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      p <= acc[PW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/bpc_temp.sv =====
// ----------------------------------------------------------------------------
// bpc_temp: temperature quadratic, rounding and saturation
// Four stages: offset, products, T3 product, sum/round/clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_temp
  import bpc_pkg::*;
#(
  parameter int TEMP_FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic [TEMP_STAGES-1:0]   en,
  input  wire calib_t                   calib,
  input  wire logic [RAW_W-1:0]         raw_pressure,
  input  wire logic [RAW_W-1:0]         raw_temperature,
  output logic [RAW_W-1:0]              r_out,
  output logic signed [TEMP_W-1:0]      t_out,
  output logic                          t_clip
);

  localparam int ST  = 48 - TEMP_FRAC_BITS;
  localparam int TQW = 64 - ST;
  localparam logic signed [63:0]    T_RND  = 64'sd1 <<< (ST - 1);
  localparam logic signed [TQW-1:0] TQ_MAX = TQW'(TEMP_MAX);
  localparam logic signed [TQW-1:0] TQ_MIN = TQW'(TEMP_MIN);

  logic [RAW_W-1:0]        r1, r2, r3;
  logic signed [24:0]      d1;
  logic signed [41:0]      m_a, a3;
  logic signed [49:0]      m_b;
  logic signed [57:0]      m3;
  logic signed [63:0]      n;
  logic signed [TQW-1:0]   tq;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r1 <= raw_pressure;
      d1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, calib.t1, 8'b0});
    end
    if (en[1]) begin
      r2  <= r1;
      m_a <= 42'(d1 * $signed(calib.t2));
      m_b <= 50'(d1 * d1);
    end
    if (en[2]) begin
      r3 <= r2;
      a3 <= m_a;
      m3 <= 58'(m_b * $signed(calib.t3));
    end
  end

  // numerator at scale 2^-48, rounded half up
  always_comb begin
    n  = (64'(a3) <<< 18) + 64'(m3) + T_RND;
    tq = TQW'(n >>> ST);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      r_out <= r3;
      if (tq > TQ_MAX) begin
        t_out  <= TEMP_W'(TQ_MAX);
        t_clip <= 1'b1;
      end else if (tq < TQ_MIN) begin
        t_out  <= TEMP_W'(TQ_MIN);
        t_clip <= 1'b1;
      end else begin
        t_out  <= tq[TEMP_W-1:0];
        t_clip <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/bpc_press.sv =====
// ----------------------------------------------------------------------------
// bpc_press: pressure polynomial as monomial products and an adder tree
// Three multiply levels, four adder levels, then round and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_press
  import bpc_pkg::*;
#(
  parameter int TEMP_FRAC_BITS  = 16,
  parameter int PRESS_FRAC_BITS = 8
) (
  input  wire logic                     clk,
  input  wire logic [PRESS_STAGES-1:0]  en,
  input  wire calib_t                   calib,
  input  wire logic [RAW_W-1:0]         r_in,
  input  wire logic signed [TEMP_W-1:0] t_in,
  input  wire logic                     t_clip,
  output logic signed [TEMP_W-1:0]      temperature_out,
  output logic [PRESS_W-1:0]            pressure_out,
  output logic                          clipped
);

  localparam int F   = TEMP_FRAC_BITS;
  localparam int DEN = (37 + 3 * F > 65) ? 37 + 3 * F : 65;
  localparam int AC  = DEN + 45;
  localparam int PSH = DEN - PRESS_FRAC_BITS;
  localparam int RW  = AC - PSH;
  localparam int NT  = 12;
  localparam logic signed [RW-1:0] RES_MAX = RW'(PRESS_MAX);

  logic signed [24:0]        rs;
  logic signed [TEMP_W-1:0]  t_pipe [PRESS_STAGES-1];
  logic                      c_pipe [PRESS_STAGES-1];
  logic signed [24:0]        r_pipe [4];

  // level 1 products
  logic signed [47:0] t2;
  logic signed [31:0] p4t, p8t, p7t;
  logic signed [32:0] p3r, p10r, p11r;
  logic signed [41:0] p2r, p1r;
  logic signed [49:0] r2;
  logic signed [48:0] rt;
  logic signed [40:0] p6t, p9r;
  // level 2 products
  logic signed [79:0] p4t3, p8t3;
  logic signed [55:0] p7t2;
  logic signed [80:0] p3rt2;
  logic signed [65:0] p2rt, p9r2;
  logic signed [81:0] p10r2t;
  logic signed [82:0] p11r3;
  // level 3 product
  logic signed [104:0] p4rt3;
  // aligned copies
  logic signed [40:0] p6t_d [4];
  logic signed [41:0] p1r_d [4];
  logic signed [55:0] p7t2_d [2];
  logic signed [79:0] p8t3_d [2];
  logic signed [65:0] p2rt_d [2];
  logic signed [80:0] p3rt2_d [2];
  logic signed [65:0] p9r2_d [2];
  logic signed [81:0] p10r2t_d [2];
  logic signed [82:0] p11r3_d [2];

  logic signed [AC-1:0] term  [NT];
  logic signed [AC-1:0] sum_a [6];
  logic signed [AC-1:0] sum_b [3];
  logic signed [AC-1:0] sum_c [2];
  logic signed [AC-1:0] sum_d;
  logic signed [RW-1:0] res;
  logic                 res_neg, res_big;

  assign rs = $signed({1'b0, r_in});

  // temperature, clip flag and raw pressure ride along
  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_pipe[0] <= t_in;
      c_pipe[0] <= t_clip;
      r_pipe[0] <= rs;
    end
    for (int k = 1; k < PRESS_STAGES - 1; k++) begin
      if (en[k]) begin
        t_pipe[k] <= t_pipe[k-1];
        c_pipe[k] <= c_pipe[k-1];
      end
    end
    for (int k = 1; k < 4; k++) begin
      if (en[k]) begin
        r_pipe[k] <= r_pipe[k-1];
      end
    end
  end

  // level 1: stages 0 and 1
  bpc_wmul #(.AW(24), .BW(24)) u_t2   (.clk, .en_a(en[0]), .en_b(en[1]),
    .a(t_in), .b(t_in), .p(t2));
  bpc_wmul #(.AW(24), .BW(8))  u_p4t  (.clk, .en_a(en[0]), .en_b(en[1]),
    .a(t_in), .b($signed(calib.p4)), .p(p4t));
  bpc_wmul #(.AW(24), .BW(8))  u_p8t  (.clk, .en_a(en[0]), .en_b(en[1]),
    .a(t_in), .b($signed(calib.p8)), .p(p8t));
  bpc_wmul #(.AW(24), .BW(8))  u_p7t  (.clk, .en_a(en[0]), .en_b(en[1]),
    .a(t_in), .b($signed(calib.p7)), .p(p7t));
  bpc_wmul #(.AW(24), .BW(17)) u_p6t  (.clk, .en_a(en[0]), .en_b(en[1]),
    .a(t_in), .b($signed(calib.p6)), .p(p6t));
  bpc_wmul #(.AW(25), .BW(8))  u_p3r  (.clk, .en_a(en[0]), .en_b(en[1]),
    .a(rs), .b($signed(calib.p3)), .p(p3r));
  bpc_wmul #(.AW(25), .BW(17)) u_p2r  (.clk, .en_a(en[0]), .en_b(en[1]),
    .a(rs), .b($signed(calib.p2)), .p(p2r));
  bpc_wmul #(.AW(25), .BW(17)) u_p1r  (.clk, .en_a(en[0]), .en_b(en[1]),
    .a(rs), .b($signed(calib.p1)), .p(p1r));
  bpc_wmul #(.AW(25), .BW(25)) u_r2   (.clk, .en_a(en[0]), .en_b(en[1]),
    .a(rs), .b(rs), .p(r2));
  bpc_wmul #(.AW(25), .BW(8))  u_p10r (.clk, .en_a(en[0]), .en_b(en[1]),
    .a(rs), .b($signed(calib.p10)), .p(p10r));
  bpc_wmul #(.AW(25), .BW(24)) u_rt   (.clk, .en_a(en[0]), .en_b(en[1]),
    .a(rs), .b(t_in), .p(rt));
  bpc_wmul #(.AW(25), .BW(8))  u_p11r (.clk, .en_a(en[0]), .en_b(en[1]),
    .a(rs), .b($signed(calib.p11)), .p(p11r));
  bpc_wmul #(.AW(25), .BW(16)) u_p9r  (.clk, .en_a(en[0]), .en_b(en[1]),
    .a(rs), .b($signed(calib.p9)), .p(p9r));

  // level 2: stages 2 and 3
  bpc_wmul #(.AW(48), .BW(32)) u_p4t3   (.clk, .en_a(en[2]), .en_b(en[3]),
    .a(t2), .b(p4t), .p(p4t3));
  bpc_wmul #(.AW(48), .BW(32)) u_p8t3   (.clk, .en_a(en[2]), .en_b(en[3]),
    .a(t2), .b(p8t), .p(p8t3));
  bpc_wmul #(.AW(32), .BW(24)) u_p7t2   (.clk, .en_a(en[2]), .en_b(en[3]),
    .a(p7t), .b(t_pipe[1]), .p(p7t2));
  bpc_wmul #(.AW(48), .BW(33)) u_p3rt2  (.clk, .en_a(en[2]), .en_b(en[3]),
    .a(t2), .b(p3r), .p(p3rt2));
  bpc_wmul #(.AW(42), .BW(24)) u_p2rt   (.clk, .en_a(en[2]), .en_b(en[3]),
    .a(p2r), .b(t_pipe[1]), .p(p2rt));
  bpc_wmul #(.AW(41), .BW(25)) u_p9r2   (.clk, .en_a(en[2]), .en_b(en[3]),
    .a(p9r), .b(r_pipe[1]), .p(p9r2));
  bpc_wmul #(.AW(49), .BW(33)) u_p10r2t (.clk, .en_a(en[2]), .en_b(en[3]),
    .a(rt), .b(p10r), .p(p10r2t));
  bpc_wmul #(.AW(50), .BW(33)) u_p11r3  (.clk, .en_a(en[2]), .en_b(en[3]),
    .a(r2), .b(p11r), .p(p11r3));

  // level 3: stages 4 and 5
  bpc_wmul #(.AW(80), .BW(25)) u_p4rt3  (.clk, .en_a(en[4]), .en_b(en[5]),
    .a(p4t3), .b(r_pipe[3]), .p(p4rt3));

  // align the shorter products with level 3
  always_ff @(posedge clk) begin
    if (en[2]) begin
      p6t_d[0] <= p6t;
      p1r_d[0] <= p1r;
    end
    for (int k = 1; k < 4; k++) begin
      if (en[k+2]) begin
        p6t_d[k] <= p6t_d[k-1];
        p1r_d[k] <= p1r_d[k-1];
      end
    end
    if (en[4]) begin
      p7t2_d[0]   <= p7t2;
      p8t3_d[0]   <= p8t3;
      p2rt_d[0]   <= p2rt;
      p3rt2_d[0]  <= p3rt2;
      p9r2_d[0]   <= p9r2;
      p10r2t_d[0] <= p10r2t;
      p11r3_d[0]  <= p11r3;
    end
    if (en[5]) begin
      p7t2_d[1]   <= p7t2_d[0];
      p8t3_d[1]   <= p8t3_d[0];
      p2rt_d[1]   <= p2rt_d[0];
      p3rt2_d[1]  <= p3rt2_d[0];
      p9r2_d[1]   <= p9r2_d[0];
      p10r2t_d[1] <= p10r2t_d[0];
      p11r3_d[1]  <= p11r3_d[0];
    end
  end

  // every term scaled to 2^-DEN; last term is the rounding half
  always_comb begin
    term[0]  = AC'($signed(calib.p5)) <<< (DEN + 3);
    term[1]  = AC'(p6t_d[3])    <<< (DEN - 6 - F);
    term[2]  = AC'(p7t2_d[1])   <<< (DEN - 8 - 2 * F);
    term[3]  = AC'(p8t3_d[1])   <<< (DEN - 15 - 3 * F);
    term[4]  = AC'(p1r_d[3])    <<< (DEN - 20);
    term[5]  = AC'(p2rt_d[1])   <<< (DEN - 29 - F);
    term[6]  = AC'(p3rt2_d[1])  <<< (DEN - 32 - 2 * F);
    term[7]  = AC'(p4rt3)       <<< (DEN - 37 - 3 * F);
    term[8]  = AC'(p9r2_d[1])   <<< (DEN - 48);
    term[9]  = AC'(p10r2t_d[1]) <<< (DEN - 48 - F);
    term[10] = AC'(p11r3_d[1])  <<< (DEN - 65);
    term[11] = AC'(1) <<< (PSH - 1);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 6; i++) begin
        sum_a[i] <= term[2*i] + term[2*i+1];
      end
    end
    if (en[7]) begin
      for (int i = 0; i < 3; i++) begin
        sum_b[i] <= sum_a[2*i] + sum_a[2*i+1];
      end
    end
    if (en[8]) begin
      sum_c[0] <= sum_b[0] + sum_b[1];
      sum_c[1] <= sum_b[2];
    end
    if (en[9]) begin
      sum_d <= sum_c[0] + sum_c[1];
    end
  end

  always_comb begin
    res     = RW'(sum_d >>> PSH);
    res_neg = res[RW-1];
    res_big = res > RES_MAX;
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      temperature_out <= t_pipe[PRESS_STAGES-2];
      clipped         <= c_pipe[PRESS_STAGES-2] | res_neg | res_big;
      if (res_neg) begin
        pressure_out <= '0;
      end else if (res_big) begin
        pressure_out <= PRESS_W'(PRESS_MAX);
      end else begin
        pressure_out <= res[PRESS_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/barometric_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation: pipelined sensor polynomial compensation
// Raw 24-bit pressure/temperature pair in, fixed-point temperature and
// saturated pressure out, calibration held in four packed registers.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   -------  ---------  ---------------------  --------------------------------
//   in       sink       in_valid / in_stall    raw_pressure, raw_temperature
//   out      source     out_valid / out_stall  temperature_out, pressure_out,
//                                              clipped
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; stages: 4 temperature
// stages, 6 stages of limb multipliers in three product levels, 4 adder-tree
// stages, 1 output register. The depth is set by r*t^3*P4, three multiplies.
// Reset clears the calibration registers and all stage valid bits.
// A stalled output stops only the stages behind it that are full; bubbles
// still close up, so items keep entering until the pipe is solid.
// cfg_ready is always high; write calibration only while the pipe is empty.
//
`default_nettype none

module barometric_pressure_compensation
  import bpc_pkg::*;
#(
  parameter int TEMP_FRAC_BITS  = 16,
  parameter int PRESS_FRAC_BITS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // sample input
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [RAW_W-1:0]         raw_pressure,
  input  wire logic [RAW_W-1:0]         raw_temperature,
  // compensated output
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [TEMP_W-1:0]      temperature_out,
  output logic [PRESS_W-1:0]            pressure_out,
  output logic                          clipped,
  // calibration writes
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data
);

  localparam int NS = TEMP_STAGES + PRESS_STAGES;

  logic [39:0]  temp_calib;
  logic [47:0]  press_calib_low;
  logic [47:0]  press_calib_mid;
  logic [31:0]  press_calib_high;
  calib_t       calib;

  logic [NS-1:0] vld;   // one valid bit per stage
  logic [NS-1:0] en;    // stage load enable

  logic [RAW_W-1:0]        r_mid;
  logic signed [TEMP_W-1:0] t_mid;
  logic                    t_clip;

  // --- calibration registers ---
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= '0;
      press_calib_low  <= '0;
      press_calib_mid  <= '0;
      press_calib_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TEMP_CALIB: temp_calib       <= cfg_data[39:0];
        CFG_PRESS_LOW:  press_calib_low  <= cfg_data;
        CFG_PRESS_MID:  press_calib_mid  <= cfg_data;
        CFG_PRESS_HIGH: press_calib_high <= cfg_data[31:0];
      endcase
    end
  end

  // unpack coefficients; P1 and P2 carry the 2^14 offset already
  always_comb begin
    calib.t1  = temp_calib[15:0];
    calib.t2  = {1'b0, temp_calib[31:16]};
    calib.t3  = temp_calib[39:32];
    calib.p1  = 17'($signed(press_calib_low[15:0])) - 17'sd16384;
    calib.p2  = 17'($signed(press_calib_low[31:16])) - 17'sd16384;
    calib.p3  = press_calib_low[39:32];
    calib.p4  = press_calib_low[47:40];
    calib.p5  = {1'b0, press_calib_mid[15:0]};
    calib.p6  = {1'b0, press_calib_mid[31:16]};
    calib.p7  = press_calib_mid[39:32];
    calib.p8  = press_calib_mid[47:40];
    calib.p9  = press_calib_high[15:0];
    calib.p10 = press_calib_high[23:16];
    calib.p11 = press_calib_high[31:24];
  end

  // --- pipeline flow control ---
  // a stage loads when it is empty or the stage after it loads
  always_comb begin
    en[NS-1] = !vld[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // --- datapath ---
  bpc_temp #(
    .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
  ) u_temp (
    .clk,
    .en              (en[TEMP_STAGES-1:0]),
    .calib,
    .raw_pressure,
    .raw_temperature,
    .r_out           (r_mid),
    .t_out           (t_mid),
    .t_clip
  );

  bpc_press #(
    .TEMP_FRAC_BITS  (TEMP_FRAC_BITS),
    .PRESS_FRAC_BITS (PRESS_FRAC_BITS)
  ) u_press (
    .clk,
    .en              (en[NS-1:TEMP_STAGES]),
    .calib,
    .r_in            (r_mid),
    .t_in            (t_mid),
    .t_clip,
    .temperature_out,
    .pressure_out,
    .clipped
  );

  // --- checks ---
  // input held off only when every stage is full and the output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with room in the pipe");

  // item count grows by one on accept without delivery
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !(out_valid && !out_stall))
      |=> ($countones(vld) == $past($countones(vld)) + 1))
    else $error("item lost or duplicated on entry");

  // item count drops by one on delivery without accept
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (!(in_valid && !in_stall) && out_valid && !out_stall)
      |=> ($countones(vld) + 1 == $past($countones(vld))))
    else $error("item lost or duplicated on exit");

  // clipped with an in-range temperature means pressure hit a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped && temperature_out != TEMP_W'(TEMP_MAX)
      && temperature_out != TEMP_W'(TEMP_MIN))
      |-> (pressure_out == '0 || pressure_out == PRESS_W'(PRESS_MAX)))
    else $error("clip flag without a saturated output");

endmodule

`default_nettype wire

// ===== tb/tb_barometric_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// tb_barometric_pressure_compensation: self-checking bench for the compensator
// Walks a table of directed samples, then randomized samples under several
// calibration sets, comparing every output item with a typed value or a
// bit-exact integer model of the calibration polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_barometric_pressure_compensation;
  import bpc_pkg::*;

  localparam int NUM_CAL_SETS = 7;
  localparam int RAND_PER_SET = 160;
  localparam int DRAIN_CYCLES = 24;     // pipe is 15 deep
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic [PRESS_W-1:0]       press;
    logic                     clip;
  } comp_result_t;

  typedef struct {
    logic [RAW_W-1:0] rp;
    logic [RAW_W-1:0] rt;
    bit               typed;   // expected value given below, else predicted
    comp_result_t     res;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [RAW_W-1:0]   raw_pressure = '0;
  logic [RAW_W-1:0]   raw_temperature = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [TEMP_W-1:0] temperature_out;
  logic [PRESS_W-1:0] pressure_out;
  logic               clipped;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  // local copy of the calibration registers
  logic [39:0] temp_cal;
  logic [47:0] press_cal_low;
  logic [47:0] press_cal_mid;
  logic [31:0] press_cal_high;

  comp_result_t pending_results[$];
  int  errors = 0;
  int  n_checked = 0;
  int  n_clipped = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;   // no idling on either side

  barometric_pressure_compensation dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .temperature_out (temperature_out),
    .pressure_out    (pressure_out),
    .clipped         (clipped),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Exact polynomial: everything held at 128 bits, the sum at scale 2^-85
  // (37 + 3*16 fractional bits), rounded half up to 1/256 Pa.
  function automatic comp_result_t compensate(logic [RAW_W-1:0] rp,
                                              logic [RAW_W-1:0] rt);
    logic signed [127:0] r, u, d, n, tq, acc;
    logic signed [127:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    comp_result_t res;
    r   = $signed({104'd0, rp});
    u   = $signed({104'd0, rt});
    t1  = $signed({112'd0, temp_cal[15:0]});
    t2  = $signed({112'd0, temp_cal[31:16]});
    t3  = 128'($signed(temp_cal[39:32]));
    p1  = 128'($signed(press_cal_low[15:0])) - 128'sd16384;
    p2  = 128'($signed(press_cal_low[31:16])) - 128'sd16384;
    p3  = 128'($signed(press_cal_low[39:32]));
    p4  = 128'($signed(press_cal_low[47:40]));
    p5  = $signed({112'd0, press_cal_mid[15:0]});
    p6  = $signed({112'd0, press_cal_mid[31:16]});
    p7  = 128'($signed(press_cal_mid[39:32]));
    p8  = 128'($signed(press_cal_mid[47:40]));
    p9  = 128'($signed(press_cal_high[15:0]));
    p10 = 128'($signed(press_cal_high[23:16]));
    p11 = 128'($signed(press_cal_high[31:24]));
    res.clip = 1'b0;

    // temperature numerator at 2^-48, rounded to 2^-16
    d  = u - t1 * 128'sd256;
    n  = d * t2 * 128'sd262144 + d * d * t3;
    tq = (n + (128'sd1 <<< 31)) >>> 32;
    if (tq > 128'(TEMP_MAX)) begin
      tq = 128'(TEMP_MAX);
      res.clip = 1'b1;
    end
    if (tq < 128'(TEMP_MIN)) begin
      tq = 128'(TEMP_MIN);
      res.clip = 1'b1;
    end
    res.temp = tq[TEMP_W-1:0];

    // pressure, using the saturated temperature
    acc = (p5 <<< 88)
        + ((p6 * tq) <<< 63)
        + ((p7 * tq * tq) <<< 45)
        + ((p8 * tq * tq * tq) <<< 22)
        + ((p1 * r) <<< 65)
        + ((p2 * r * tq) <<< 40)
        + ((p3 * r * tq * tq) <<< 21)
        + (p4 * r * tq * tq * tq)
        + ((p9 * r * r) <<< 37)
        + ((p10 * r * r * tq) <<< 21)
        + ((p11 * r * r * r) <<< 20);
    acc = (acc + (128'sd1 <<< 76)) >>> 77;
    if (acc < 128'sd0) begin
      res.press = '0;
      res.clip  = 1'b1;
    end else if (acc > 128'(PRESS_MAX)) begin
      res.press = PRESS_W'(PRESS_MAX);
      res.clip  = 1'b1;
    end else begin
      res.press = acc[PRESS_W-1:0];
    end
    return res;
  endfunction

  // writes one calibration register; only called with the pipe empty
  task automatic write_cal(cfg_reg_t idx, logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TEMP_CALIB: temp_cal       = value[39:0];
      CFG_PRESS_LOW:  press_cal_low  = value[47:0];
      CFG_PRESS_MID:  press_cal_mid  = value[47:0];
      CFG_PRESS_HIGH: press_cal_high = value[31:0];
      default: ;
    endcase
    // stay idle between writes
    @(posedge clk);
  endtask

  // one sample; expectation queued at the accepting edge
  task automatic send_sample(logic [RAW_W-1:0] rp, logic [RAW_W-1:0] rt,
                             bit typed, comp_result_t typed_res);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    raw_pressure    <= rp;
    raw_temperature <= rt;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(typed ? typed_res : compensate(rp, rt));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver idling: random stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // output checker
  always @(posedge clk) begin
    comp_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected output item: temp %0d press %0d", temperature_out,
               pressure_out);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (clipped) n_clipped++;
        if (temperature_out !== want.temp) begin
          $error("temperature_out: expected %0d, got %0d", want.temp, temperature_out);
          errors++;
        end
        if (pressure_out !== want.press) begin
          $error("pressure_out: expected %0d, got %0d", want.press, pressure_out);
          errors++;
        end
        if (clipped !== want.clip) begin
          $error("clipped: expected %0b, got %0b", want.clip, clipped);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  sample_row_t directed[10];
  logic [39:0] cal_t[NUM_CAL_SETS];
  logic [47:0] cal_l[NUM_CAL_SETS];
  logic [47:0] cal_m[NUM_CAL_SETS];
  logic [31:0] cal_h[NUM_CAL_SETS];

  initial begin
    comp_result_t none;
    logic [RAW_W-1:0] rp, rt;
    int centre;
    none = '{temp: '0, press: '0, clip: 1'b0};

    // After reset all calibration is zero: t = 0, and p = -r/64, so any
    // nonzero raw pressure goes negative and clips to zero.
    directed[0] = '{24'h000000, 24'h000000, 1, '{0, 0, 1'b0}};
    directed[1] = '{24'hFFFFFF, 24'h000000, 1, '{0, 0, 1'b1}};
    directed[2] = '{24'h000000, 24'hFFFFFF, 1, '{0, 0, 1'b0}};
    directed[3] = '{24'hFFFFFF, 24'hFFFFFF, 1, '{0, 0, 1'b1}};
    directed[4] = '{24'h000001, 24'h000000, 1, '{0, 0, 1'b1}};
    directed[5] = '{24'h800000, 24'h800000, 0, none};
    directed[6] = '{24'h555555, 24'hAAAAAA, 0, none};
    directed[7] = '{24'hAAAAAA, 24'h555555, 0, none};
    directed[8] = '{24'h7FFFFF, 24'h000001, 0, none};
    directed[9] = '{24'h6B7000, 24'h6B7000, 0, none};

    // calibration sets: all ones, hot saturation, a plausible sensor,
    // random ones, and back to zero
    cal_t[0] = '1;  cal_l[0] = '1;  cal_m[0] = '1;  cal_h[0] = '1;
    cal_t[1] = {8'h7F, 16'hFFFF, 16'h0000};
    cal_l[1] = {8'h80, 8'h7F, 16'h8000, 16'h7FFF};
    cal_m[1] = {8'h80, 8'h7F, 16'hFFFF, 16'h0000};
    cal_h[1] = {8'h7F, 8'h80, 16'h7FFF};
    cal_t[2] = {8'hF9, 16'd19140, 16'd27504};
    cal_l[2] = {8'h00, 8'h20, 16'h3F00, 16'h4100};
    cal_m[2] = {8'h00, 8'h03, 16'h5000, 16'h4E20};
    cal_h[2] = 32'h0000_1000;
    for (int k = 3; k < NUM_CAL_SETS - 1; k++) begin
      cal_t[k] = 40'({$urandom, $urandom});
      cal_l[k] = 48'({$urandom, $urandom});
      cal_m[k] = 48'({$urandom, $urandom});
      cal_h[k] = $urandom;
    end
    cal_t[NUM_CAL_SETS-1] = '0;
    cal_l[NUM_CAL_SETS-1] = '0;
    cal_m[NUM_CAL_SETS-1] = '0;
    cal_h[NUM_CAL_SETS-1] = '0;

    temp_cal = '0;
    press_cal_low = '0;
    press_cal_mid = '0;
    press_cal_high = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table against reset calibration
    foreach (directed[i])
      send_sample(directed[i].rp, directed[i].rt, directed[i].typed, directed[i].res);
    drain();

    for (int k = 0; k < NUM_CAL_SETS; k++) begin
      write_cal(CFG_TEMP_CALIB, {8'h0, cal_t[k]});
      write_cal(CFG_PRESS_LOW,  cal_l[k]);
      write_cal(CFG_PRESS_MID,  cal_m[k]);
      write_cal(CFG_PRESS_HIGH, {16'h0, cal_h[k]});
      // final set runs with both sides busy every cycle
      quiet = (k == NUM_CAL_SETS - 1);

      // extremes again under the all-ones and hot saturation sets
      if (k <= 1)
        foreach (directed[i]) send_sample(directed[i].rp, directed[i].rt, 0, none);

      centre = int'(cal_t[k][15:0]) * 256;
      for (int i = 0; i < RAND_PER_SET; i++) begin
        if ($urandom_range(0, 9) < 6) begin
          // near the calibration point
          rt = RAW_W'(centre + $urandom_range(0, 1 << 21) - (1 << 20));
          rp = RAW_W'(24'h800000 + $urandom_range(0, 1 << 22) - (1 << 21));
        end else begin
          rt = RAW_W'($urandom);
          rp = RAW_W'($urandom);
        end
        send_sample(rp, rt, 0, none);
      end
      drain();
    end

    $display("Checked %0d output items (%0d clipped) over %0d calibration sets.",
             n_checked, n_clipped, NUM_CAL_SETS + 1);
    $display("Directed extremes, saturation both ways, random and near-center samples.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
